@@ hdl/bbpp_pkg.sv @@
// Shared types and constants for the bicubic Bezier patch point evaluator.
`default_nettype none

package bbpp_pkg;

    localparam int TAB_DEPTH    = 16;
    localparam int TAB_IDX_BITS = 4;
    localparam int GRID_BITS    = 2;
    localparam int NUM_WT       = 4;
    localparam int BAND_BITS    = 2;
    localparam int CFG_IDX_BITS = 1;

    localparam int BAND_ONE_PCT = 17;
    localparam int BAND_TWO_PCT = 34;
    localparam int PCT_SCALE    = 100;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_EVAL = 1'b1
    } t_kind;

    typedef enum logic [BAND_BITS-1:0] {
        BAND_ZERO = 2'd0,
        BAND_ONE  = 2'd1,
        BAND_TWO  = 2'd2
    } t_band;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BAND_ONE = 1'b0,
        CFG_BAND_TWO = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic so;
    } t_stage_en;

endpackage

`default_nettype wire

@@ hdl/bbpp_ifs.sv @@
// Channel interfaces of the patch point evaluator: items, results and configuration.
`default_nettype none

interface bbpp_item_if #(
    parameter int FRAC_BITS  = 16,
    parameter int COORD_BITS = 10
);
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [bbpp_pkg::GRID_BITS-1:0] point_row;
    logic [bbpp_pkg::GRID_BITS-1:0] point_col;
    logic [COORD_BITS-1:0]          point_x;
    logic [COORD_BITS-1:0]          point_y;
    logic [FRAC_BITS:0]             param_u;
    logic [FRAC_BITS:0]             param_w;

    modport source (
        output valid, kind, point_row, point_col, point_x, point_y, param_u, param_w,
        input  ready
    );
    modport sink (
        input  valid, kind, point_row, point_col, point_x, point_y, param_u, param_w,
        output ready
    );
endinterface

interface bbpp_result_if #(
    parameter int COORD_BITS = 10
);
    logic                           valid;
    logic                           ready;
    logic [COORD_BITS-1:0]          surface_x;
    logic [COORD_BITS-1:0]          surface_y;
    logic [bbpp_pkg::BAND_BITS-1:0] colour_band;

    modport source (
        output valid, surface_x, surface_y, colour_band,
        input  ready
    );
    modport sink (
        input  valid, surface_x, surface_y, colour_band,
        output ready
    );
endinterface

interface bbpp_cfg_if #(
    parameter int FRAC_BITS = 16
);
    logic                              valid;
    logic                              ready;
    logic [bbpp_pkg::CFG_IDX_BITS-1:0] index;
    logic [FRAC_BITS:0]                data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

@@ hdl/bbpp_weights.sv @@
// Two-stage pipelined cubic Bernstein weight generator for one parameter.
`default_nettype none

module bbpp_weights #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire bbpp_pkg::t_stage_en  i_en,
    input  wire logic [FRAC_BITS:0]   i_t,
    input  wire logic [FRAC_BITS:0]   i_s,
    output logic      [FRAC_BITS:0]   o_wt [bbpp_pkg::NUM_WT]
);

    localparam int PW = FRAC_BITS + 1;
    localparam int MW = 2 * PW;

    logic [PW-1:0] r_t;
    logic [PW-1:0] r_s;
    logic [PW-1:0] r_tt;
    logic [PW-1:0] r_ss;
    logic [PW-1:0] r_ts;
    logic [PW-1:0] r_wt [bbpp_pkg::NUM_WT];

    logic [MW-1:0] w_tt_p;
    logic [MW-1:0] w_ss_p;
    logic [MW-1:0] w_ts_p;
    logic [MW-1:0] w_p0;
    logic [MW-1:0] w_p1;
    logic [MW-1:0] w_p2;
    logic [MW-1:0] w_p3;
    logic [PW+1:0] w_wt1;
    logic [PW+1:0] w_wt2;

    always_comb begin
        w_tt_p = {{PW{1'b0}}, i_t} * {{PW{1'b0}}, i_t};
        w_ss_p = {{PW{1'b0}}, i_s} * {{PW{1'b0}}, i_s};
        w_ts_p = {{PW{1'b0}}, i_t} * {{PW{1'b0}}, i_s};
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_t  <= i_t;
            r_s  <= i_s;
            r_tt <= w_tt_p[FRAC_BITS +: PW];
            r_ss <= w_ss_p[FRAC_BITS +: PW];
            r_ts <= w_ts_p[FRAC_BITS +: PW];
        end
    end

    always_comb begin
        w_p0  = {{PW{1'b0}}, r_ss} * {{PW{1'b0}}, r_s};
        w_p1  = {{PW{1'b0}}, r_ts} * {{PW{1'b0}}, r_s};
        w_p2  = {{PW{1'b0}}, r_ts} * {{PW{1'b0}}, r_t};
        w_p3  = {{PW{1'b0}}, r_tt} * {{PW{1'b0}}, r_t};
        w_wt1 = {2'b00, w_p1[FRAC_BITS +: PW]} + {1'b0, w_p1[FRAC_BITS +: PW], 1'b0};
        w_wt2 = {2'b00, w_p2[FRAC_BITS +: PW]} + {1'b0, w_p2[FRAC_BITS +: PW], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_wt[0] <= w_p0[FRAC_BITS +: PW];
            r_wt[1] <= w_wt1[PW-1:0];
            r_wt[2] <= w_wt2[PW-1:0];
            r_wt[3] <= w_p3[FRAC_BITS +: PW];
        end
    end

    assign o_wt = r_wt;

endmodule

`default_nettype wire

@@ hdl/bbpp_blend.sv @@
// Three-stage blend of the control grid with row and column weights for one coordinate.
`default_nettype none

module bbpp_blend #(
    parameter int FRAC_BITS  = 16,
    parameter int COORD_BITS = 10
) (
    input  wire logic                  i_clk,
    input  wire bbpp_pkg::t_stage_en   i_en,
    input  wire logic [COORD_BITS-1:0] i_entry   [bbpp_pkg::TAB_DEPTH],
    input  wire logic [FRAC_BITS:0]    i_row_wt  [bbpp_pkg::NUM_WT],
    input  wire logic [FRAC_BITS:0]    i_col_wt  [bbpp_pkg::NUM_WT],
    output logic      [COORD_BITS-1:0] o_coord
);

    localparam int PW  = FRAC_BITS + 1;
    localparam int PRW = PW + COORD_BITS;
    localparam int RW  = PRW + 2;
    localparam int HW  = RW - FRAC_BITS;
    localparam int HPW = HW + PW;
    localparam int LPW = FRAC_BITS + PW;
    localparam int TW  = HPW + 1;
    localparam int SW  = TW + 2;
    localparam int NW  = bbpp_pkg::NUM_WT;

    logic [RW-1:0]         r_col_sum [NW];
    logic [PW-1:0]         r_col_wt  [NW];
    logic [TW-1:0]         r_term    [NW];
    logic [COORD_BITS-1:0] r_coord;

    logic [PRW-1:0]        w_prod    [NW][NW];
    logic [RW-1:0]         w_col_sum [NW];
    logic [HPW-1:0]        w_hi_p    [NW];
    logic [LPW-1:0]        w_lo_p    [NW];
    logic [TW-1:0]         w_term    [NW];
    logic [SW-1:0]         w_total;
    logic [SW-FRAC_BITS-1:0] w_whole;
    logic [COORD_BITS-1:0] w_sat;

    always_comb begin
        for (int c = 0; c < NW; c++) begin
            w_col_sum[c] = '0;
            for (int r = 0; r < NW; r++) begin
                w_prod[r][c] = {{COORD_BITS{1'b0}}, i_row_wt[r]}
                             * {{PW{1'b0}},
                                i_entry[bbpp_pkg::TAB_IDX_BITS'(r * NW + c)]};
                w_col_sum[c] = w_col_sum[c] + {2'b00, w_prod[r][c]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_col_sum <= w_col_sum;
            r_col_wt  <= i_col_wt;
        end
    end

    always_comb begin
        for (int c = 0; c < NW; c++) begin
            w_hi_p[c] = {{PW{1'b0}}, r_col_sum[c][RW-1:FRAC_BITS]}
                      * {{HW{1'b0}}, r_col_wt[c]};
            w_lo_p[c] = {{PW{1'b0}}, r_col_sum[c][FRAC_BITS-1:0]}
                      * {{FRAC_BITS{1'b0}}, r_col_wt[c]};
            w_term[c] = {1'b0, w_hi_p[c]} + {{(TW-PW){1'b0}}, w_lo_p[c][FRAC_BITS +: PW]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            r_term <= w_term;
        end
    end

    always_comb begin
        w_total = '0;
        for (int c = 0; c < NW; c++) begin
            w_total = w_total + {2'b00, r_term[c]};
        end
        w_whole = w_total[SW-1:FRAC_BITS];
        if (|w_whole[SW-FRAC_BITS-1:COORD_BITS]) begin
            w_sat = '1;
        end else begin
            w_sat = w_whole[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.so) begin
            r_coord <= w_sat;
        end
    end

    assign o_coord = r_coord;

endmodule

`default_nettype wire

@@ hdl/bicubic_bezier_patch_point.sv @@
// Top level of the bicubic Bezier patch point evaluator.
// Load transactions write one entry of the 4x4 control grid and give no result; evaluate
// transactions give the patch point at (u, w), truncated to whole pixels and saturated, plus a
// colour band from comparing the unclamped u with the two limit registers. A new transaction is
// taken every cycle that ready is high; a result passes through six register stages (input
// capture, two Bernstein multiply stages, grid row sum, column weighting, final sum and
// saturation). Stages advance independently, so a held result stalls only the stages behind it
// that are full. A load takes effect for every evaluation accepted after it, including one
// accepted in the very next cycle. The grid must be fully loaded before the first evaluation;
// the user must write limit registers only while the pipeline is empty, which is not enforced.
`default_nettype none

module bicubic_bezier_patch_point #(
    parameter int FRAC_BITS  = 16,
    parameter int COORD_BITS = 10
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    bbpp_item_if.sink      i_item,
    bbpp_cfg_if.sink       i_cfg,
    bbpp_result_if.source  o_result
);

    localparam int PW = FRAC_BITS + 1;
    localparam int GB = bbpp_pkg::GRID_BITS;
    localparam logic [PW-1:0] ONE_FIX = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [PW-1:0] BAND_ONE_RST =
        PW'((64'(bbpp_pkg::BAND_ONE_PCT) << FRAC_BITS) / bbpp_pkg::PCT_SCALE);
    localparam logic [PW-1:0] BAND_TWO_RST =
        PW'((64'(bbpp_pkg::BAND_TWO_PCT) << FRAC_BITS) / bbpp_pkg::PCT_SCALE);

    bbpp_pkg::t_stage_en w_en;
    logic                w_in_en;

    logic [PW-1:0] r_band_one;
    logic [PW-1:0] r_band_two;

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;
    logic r_v5;
    logic r_ov;

    logic [PW-1:0] w_u_cl;
    logic [PW-1:0] w_w_cl;
    bbpp_pkg::t_band w_band;

    logic [PW-1:0]         r_u_t;
    logic [PW-1:0]         r_u_s;
    logic [PW-1:0]         r_w_t;
    logic [PW-1:0]         r_w_s;
    bbpp_pkg::t_kind       r_kind1;
    bbpp_pkg::t_kind       r_kind2;
    bbpp_pkg::t_kind       r_kind3;
    logic [GB-1:0]         r_row1;
    logic [GB-1:0]         r_row2;
    logic [GB-1:0]         r_row3;
    logic [GB-1:0]         r_col1;
    logic [GB-1:0]         r_col2;
    logic [GB-1:0]         r_col3;
    logic [COORD_BITS-1:0] r_x1;
    logic [COORD_BITS-1:0] r_x2;
    logic [COORD_BITS-1:0] r_x3;
    logic [COORD_BITS-1:0] r_y1;
    logic [COORD_BITS-1:0] r_y2;
    logic [COORD_BITS-1:0] r_y3;
    bbpp_pkg::t_band       r_band1;
    bbpp_pkg::t_band       r_band2;
    bbpp_pkg::t_band       r_band3;
    bbpp_pkg::t_band       r_band4;
    bbpp_pkg::t_band       r_band5;
    bbpp_pkg::t_band       r_out_band;

    logic [COORD_BITS-1:0] r_tab_x [bbpp_pkg::TAB_DEPTH];
    logic [COORD_BITS-1:0] r_tab_y [bbpp_pkg::TAB_DEPTH];

    logic [PW-1:0]         w_row_wt [bbpp_pkg::NUM_WT];
    logic [PW-1:0]         w_col_wt [bbpp_pkg::NUM_WT];
    logic [COORD_BITS-1:0] w_sx;
    logic [COORD_BITS-1:0] w_sy;
    logic                  w_tab_we;

    always_comb begin
        w_en.so = !r_ov || o_result.ready;
        w_en.s5 = !r_v5 || w_en.so;
        w_en.s4 = !r_v4 || w_en.s5;
        w_en.s3 = !r_v3 || w_en.s4;
        w_en.s2 = !r_v2 || w_en.s3;
        w_in_en = !r_v1 || w_en.s2;
    end

    assign i_item.ready = w_in_en;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_one <= BAND_ONE_RST;
            r_band_two <= BAND_TWO_RST;
        end else if (i_cfg.valid) begin
            case (bbpp_pkg::t_cfg_reg'(i_cfg.index))
                bbpp_pkg::CFG_BAND_ONE: r_band_one <= i_cfg.data;
                bbpp_pkg::CFG_BAND_TWO: r_band_two <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_u_cl = (i_item.param_u > ONE_FIX) ? ONE_FIX : i_item.param_u;
        w_w_cl = (i_item.param_w > ONE_FIX) ? ONE_FIX : i_item.param_w;
        if (i_item.param_u < r_band_one) begin
            w_band = bbpp_pkg::BAND_ZERO;
        end else if (i_item.param_u < r_band_two) begin
            w_band = bbpp_pkg::BAND_ONE;
        end else begin
            w_band = bbpp_pkg::BAND_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_in_en) begin
                r_v1 <= i_item.valid;
            end
            if (w_en.s2) begin
                r_v2 <= r_v1;
            end
            if (w_en.s3) begin
                r_v3 <= r_v2;
            end
            if (w_en.s4) begin
                r_v4 <= r_v3 && (r_kind3 == bbpp_pkg::KIND_EVAL);
            end
            if (w_en.s5) begin
                r_v5 <= r_v4;
            end
            if (w_en.so) begin
                r_ov <= r_v5;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_en) begin
            r_u_t   <= w_u_cl;
            r_u_s   <= ONE_FIX - w_u_cl;
            r_w_t   <= w_w_cl;
            r_w_s   <= ONE_FIX - w_w_cl;
            r_kind1 <= bbpp_pkg::t_kind'(i_item.kind);
            r_row1  <= i_item.point_row;
            r_col1  <= i_item.point_col;
            r_x1    <= i_item.point_x;
            r_y1    <= i_item.point_y;
            r_band1 <= w_band;
        end
        if (w_en.s2) begin
            r_kind2 <= r_kind1;
            r_row2  <= r_row1;
            r_col2  <= r_col1;
            r_x2    <= r_x1;
            r_y2    <= r_y1;
            r_band2 <= r_band1;
        end
        if (w_en.s3) begin
            r_kind3 <= r_kind2;
            r_row3  <= r_row2;
            r_col3  <= r_col2;
            r_x3    <= r_x2;
            r_y3    <= r_y2;
            r_band3 <= r_band2;
        end
        if (w_en.s4) begin
            r_band4 <= r_band3;
        end
        if (w_en.s5) begin
            r_band5 <= r_band4;
        end
        if (w_en.so) begin
            r_out_band <= r_band5;
        end
    end

    // A load writes the grid as it leaves the stage where evaluations read it,
    // so evaluations ahead of it see the old entry and those behind it the new one.
    assign w_tab_we = r_v3 && (r_kind3 == bbpp_pkg::KIND_LOAD) && w_en.s4;

    always_ff @(posedge i_clk) begin
        if (w_tab_we) begin
            r_tab_x[{r_row3, r_col3}] <= r_x3;
            r_tab_y[{r_row3, r_col3}] <= r_y3;
        end
    end

    bbpp_weights #(
        .FRAC_BITS (FRAC_BITS)
    ) u_row_weights (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_t   (r_u_t),
        .i_s   (r_u_s),
        .o_wt  (w_row_wt)
    );

    bbpp_weights #(
        .FRAC_BITS (FRAC_BITS)
    ) u_col_weights (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_t   (r_w_t),
        .i_s   (r_w_s),
        .o_wt  (w_col_wt)
    );

    bbpp_blend #(
        .FRAC_BITS  (FRAC_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_blend_x (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_entry  (r_tab_x),
        .i_row_wt (w_row_wt),
        .i_col_wt (w_col_wt),
        .o_coord  (w_sx)
    );

    bbpp_blend #(
        .FRAC_BITS  (FRAC_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_blend_y (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_entry  (r_tab_y),
        .i_row_wt (w_row_wt),
        .i_col_wt (w_col_wt),
        .o_coord  (w_sy)
    );

    assign o_result.valid       = r_ov;
    assign o_result.surface_x   = w_sx;
    assign o_result.surface_y   = w_sy;
    assign o_result.colour_band = r_out_band;

    a_load_gives_no_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && (r_kind3 == bbpp_pkg::KIND_LOAD) && w_en.s4) |=> !r_v4
    ) else $error("A load transaction entered the result stages.");

    a_stage5_held_on_stall: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && !w_en.so) |=> (r_v5 && $stable(r_band5))
    ) else $error("A stalled item in the final stage was lost.");

    a_result_from_stage5: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (!r_v5 && !r_ov) |=> !r_ov
    ) else $error("A result appeared without an item in the final stage.");

endmodule

`default_nettype wire
